@@ hdl/x25rx_pkg.sv @@
// Shared types and constants for the X.25 packet-layer receive state machine.
// Used by the front, queue, back and top-level modules; no dependencies.
package x25rx_pkg;

  // Sequence number and register widths
  localparam int unsigned SeqW   = 3;
  localparam int unsigned TicksW = 16;
  localparam int unsigned WinW   = 3;
  localparam int unsigned ActW   = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RESET_TICKS  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLDBACK     = 2'd2;

  // Configuration reset values
  localparam logic [WinW-1:0]   WINDOW_RESET    = 3'd2;
  localparam logic [TicksW-1:0] RST_TICKS_RESET = 16'd180;
  localparam logic [TicksW-1:0] HOLDBACK_RESET  = 16'd50;

  // Raw action codes on the input stream
  typedef enum logic [ActW-1:0] {
    ACT_CALL_ACCEPTED = 4'd0,
    ACT_CLEAR_REQ     = 4'd1,
    ACT_CLEAR_CONF    = 4'd2,
    ACT_RESET_REQ     = 4'd3,
    ACT_RESET_CONF    = 4'd4,
    ACT_RR            = 4'd5,
    ACT_RNR           = 4'd6,
    ACT_DATA          = 4'd7,
    ACT_UNKNOWN       = 4'd8,
    ACT_CALL_SENT     = 4'd9,
    ACT_CLEAR_SENT    = 4'd10,
    ACT_DATA_SENT     = 4'd11
  } action_e;

  // Classified event kind carried through the queue
  typedef enum logic [3:0] {
    KIND_UNKNOWN,
    KIND_CALL_ACCEPTED,
    KIND_CLEAR_REQ,
    KIND_CLEAR_CONF,
    KIND_RESET_REQ,
    KIND_RESET_CONF,
    KIND_RR,
    KIND_RNR,
    KIND_DATA,
    KIND_CALL_SENT,
    KIND_CLEAR_SENT,
    KIND_DATA_SENT
  } kind_e;

  // Circuit state
  typedef enum logic [2:0] {
    MODE_IDLE          = 3'd0,
    MODE_AWAIT_ACCEPT  = 3'd1,
    MODE_AWAIT_CLEAR   = 3'd2,
    MODE_CONNECTED     = 3'd3,
    MODE_AWAIT_RESET   = 3'd4
  } mode_e;

  // Packet to send
  typedef enum logic [2:0] {
    SEND_NONE       = 3'd0,
    SEND_RESET_CONF = 3'd1,
    SEND_CLEAR_CONF = 3'd2,
    SEND_RESET_REQ  = 3'd3,
    SEND_RR         = 3'd4,
    SEND_RNR        = 3'd5
  } send_e;

  // Status code
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_REFUSED    = 2'd1,
    STAT_UNEXPECTED = 2'd2
  } status_e;

  // One classified item in the queue
  typedef struct packed {
    kind_e           kind;
    logic [SeqW-1:0] rx_seq;
    logic [SeqW-1:0] ack_seq;
    logic            more_bit;
    logic            rx_space_ok;
  } item_t;

  // One result item
  typedef struct packed {
    logic              own_busy;
    logic              peer_busy;
    status_e           status_code;
    logic [TicksW-1:0] timer_value;
    logic              timer_write;
    logic              flush_queues;
    mode_e             circuit_state;
    logic              ack_update;
    logic [SeqW-1:0]   acked_upto;
    logic              more_follows;
    logic              deliver;
    send_e             send_packet;
  } result_t;

  // Configuration registers as seen by the back end
  typedef struct packed {
    logic [WinW-1:0]   window_size;
    logic [TicksW-1:0] reset_timer_ticks;
    logic [TicksW-1:0] holdback_ticks;
  } cfg_t;

  // Queue status toward the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ hdl/x25_packet_layer_rx_fsm_unit.sv @@
// Top level of the X.25 packet-layer receive state machine (modulo 8).
// Depends on x25rx_pkg, x25rx_front, x25rx_queue and x25rx_back.
//
// Usage:
//   s_axis carries one decoded packet or local event per transfer; m_axis
//   returns exactly one result per input transfer, in order. The cfg port
//   writes window_size (index 0), reset_timer_ticks (1) and holdback_ticks (2)
//   on any clock edge with cfg_we_i high; write only while the block is idle.
// Path: the front register loads at the input transfer edge, then the queue
//   entry, then the result register, which raises m_axis_tvalid; the result
//   transfer completes when m_axis_tready is high.
// Throughput: one item per cycle while m_axis_tready is high; the back end
//   retires one queued event each cycle, as the next state is computed combinationally.
// Reset: circuit state goes to idle, V(S), V(A), V(R), V(L) and all flags to
//   zero, configuration to window 2, reset timer 180, hold-back 50.
// Stall: when m_axis_tready is low the result register holds; the two-entry
//   queue and the front register absorb up to three more items before
//   s_axis_tready drops. Nothing is lost or repeated.
module x25_packet_layer_rx_fsm_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // action[3:0], rx_seq[6:4], ack_seq[9:7], more_bit[10], rx_space_ok[11]
  input  logic [x25rx_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // send_packet[2:0], deliver[3], more_follows[4], acked_upto[7:5],
  // ack_update[8], circuit_state[11:9], flush_queues[12], timer_write[13],
  // timer_value[29:14], status_code[31:30], peer_busy[32], own_busy[33]
  output logic [x25rx_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_we_i,
  input  logic [x25rx_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [x25rx_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  x25rx_pkg::cfg_t      cfg_q;
  x25rx_pkg::q_status_t q_status;
  x25rx_pkg::item_t     push_item;
  x25rx_pkg::item_t     head;
  x25rx_pkg::result_t   result;
  logic                 push;
  logic                 pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_size       <= x25rx_pkg::WINDOW_RESET;
      cfg_q.reset_timer_ticks <= x25rx_pkg::RST_TICKS_RESET;
      cfg_q.holdback_ticks    <= x25rx_pkg::HOLDBACK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        x25rx_pkg::CFG_WINDOW_SIZE: cfg_q.window_size       <= cfg_wdata_i[x25rx_pkg::WinW-1:0];
        x25rx_pkg::CFG_RESET_TICKS: cfg_q.reset_timer_ticks <= cfg_wdata_i;
        x25rx_pkg::CFG_HOLDBACK:    cfg_q.holdback_ticks    <= cfg_wdata_i;
        default: begin
          // Unused index: drop the write
        end
      endcase
    end
  end

  x25rx_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .action_i      (s_axis_tdata[3:0]),
    .rx_seq_i      (s_axis_tdata[6:4]),
    .ack_seq_i     (s_axis_tdata[9:7]),
    .more_bit_i    (s_axis_tdata[10]),
    .rx_space_ok_i (s_axis_tdata[11]),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  x25rx_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  x25rx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .q_empty_i   (q_status.empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  // Pack the result, zero-filled to whole bytes
  assign m_axis_tdata = {6'd0, result};

endmodule

@@ hdl/x25rx_front.sv @@
// Front end: takes input transfers, decodes the action into an event kind
// and hands the classified item to the queue. Depends on x25rx_pkg.
module x25rx_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [x25rx_pkg::ActW-1:0] action_i,
  input  logic [x25rx_pkg::SeqW-1:0] rx_seq_i,
  input  logic [x25rx_pkg::SeqW-1:0] ack_seq_i,
  input  logic                     more_bit_i,
  input  logic                     rx_space_ok_i,
  input  x25rx_pkg::q_status_t     q_status_i,
  output logic                     push_o,
  output x25rx_pkg::item_t         push_item_o
);

  logic                 valid_q, valid_d;
  x25rx_pkg::item_t     item_q, item_d;
  x25rx_pkg::kind_e     kind;
  logic                 accept;

  // Decode the action code
  always_comb begin
    unique case (x25rx_pkg::action_e'(action_i))
      x25rx_pkg::ACT_CALL_ACCEPTED: kind = x25rx_pkg::KIND_CALL_ACCEPTED;
      x25rx_pkg::ACT_CLEAR_REQ:     kind = x25rx_pkg::KIND_CLEAR_REQ;
      x25rx_pkg::ACT_CLEAR_CONF:    kind = x25rx_pkg::KIND_CLEAR_CONF;
      x25rx_pkg::ACT_RESET_REQ:     kind = x25rx_pkg::KIND_RESET_REQ;
      x25rx_pkg::ACT_RESET_CONF:    kind = x25rx_pkg::KIND_RESET_CONF;
      x25rx_pkg::ACT_RR:            kind = x25rx_pkg::KIND_RR;
      x25rx_pkg::ACT_RNR:           kind = x25rx_pkg::KIND_RNR;
      x25rx_pkg::ACT_DATA:          kind = x25rx_pkg::KIND_DATA;
      x25rx_pkg::ACT_CALL_SENT:     kind = x25rx_pkg::KIND_CALL_SENT;
      x25rx_pkg::ACT_CLEAR_SENT:    kind = x25rx_pkg::KIND_CLEAR_SENT;
      x25rx_pkg::ACT_DATA_SENT:     kind = x25rx_pkg::KIND_DATA_SENT;
      default:                      kind = x25rx_pkg::KIND_UNKNOWN;
    endcase
  end

  // Hand over to the queue whenever it has room
  assign push_o      = valid_q && !q_status_i.full;
  assign push_item_o = item_q;
  assign in_ready_o  = !valid_q || !q_status_i.full;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d             = 1'b1;
      item_d.kind         = kind;
      item_d.rx_seq       = rx_seq_i;
      item_d.ack_seq      = ack_seq_i;
      item_d.more_bit     = more_bit_i;
      item_d.rx_space_ok  = rx_space_ok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

@@ hdl/x25rx_queue.sv @@
// Two-entry queue between the front end and the back end.
// Depends on x25rx_pkg for the item type.
module x25rx_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  x25rx_pkg::item_t     push_item_i,
  input  logic                 pop_i,
  output x25rx_pkg::item_t     head_o,
  output x25rx_pkg::q_status_t status_o
);

  x25rx_pkg::item_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign head_o         = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ hdl/x25rx_back.sv @@
// Back end: executes one queued event per cycle, while the output register is
// free or being drained, against the circuit state and holds the result in an output register. Depends on x25rx_pkg.
module x25rx_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  x25rx_pkg::cfg_t      cfg_i,
  input  x25rx_pkg::item_t     head_i,
  input  logic                 q_empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output x25rx_pkg::result_t   result_o
);

  localparam int unsigned SeqW = x25rx_pkg::SeqW;

  x25rx_pkg::mode_e   mode_q, mode_d;
  logic [SeqW-1:0]    vs_q, vs_d;
  logic [SeqW-1:0]    va_q, va_d;
  logic [SeqW-1:0]    vr_q, vr_d;
  logic [SeqW-1:0]    vl_q, vl_d;
  logic               peer_q, peer_d;
  logic               own_q, own_d;
  logic               ackp_q, ackp_d;
  logic               out_valid_q, out_valid_d;
  x25rx_pkg::result_t res_q, res_d;
  logic [SeqW-1:0]    nr_off;
  logic [SeqW-1:0]    nr_span;
  logic [SeqW-1:0]    ack_mark;
  logic               nr_ok;

  // Take the next event when the output register is free or being drained
  assign pop_o       = !q_empty_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  // N(R) window check against V(A)..V(S)
  assign nr_off  = head_i.ack_seq - va_q;
  assign nr_span = vs_q - va_q;
  assign nr_ok   = (nr_off <= nr_span);

  // Next circuit state and result
  always_comb begin
    mode_d   = mode_q;
    vs_d     = vs_q;
    va_d     = va_q;
    vr_d     = vr_q;
    vl_d     = vl_q;
    peer_d   = peer_q;
    own_d    = own_q;
    ackp_d   = ackp_q;
    ack_mark = '0;
    res_d    = '0;
    res_d.send_packet = x25rx_pkg::SEND_NONE;
    res_d.status_code = x25rx_pkg::STAT_OK;

    unique case (head_i.kind)
      x25rx_pkg::KIND_UNKNOWN: begin
        res_d.status_code = x25rx_pkg::STAT_UNEXPECTED;
      end
      x25rx_pkg::KIND_CALL_SENT: begin
        if (mode_q == x25rx_pkg::MODE_IDLE) begin
          vs_d = '0; va_d = '0; vr_d = '0; vl_d = '0;
          peer_d = 1'b0; own_d = 1'b0; ackp_d = 1'b0;
          mode_d = x25rx_pkg::MODE_AWAIT_ACCEPT;
        end else begin
          res_d.status_code = x25rx_pkg::STAT_UNEXPECTED;
        end
      end
      x25rx_pkg::KIND_CLEAR_SENT: begin
        if (mode_q == x25rx_pkg::MODE_AWAIT_ACCEPT || mode_q == x25rx_pkg::MODE_CONNECTED ||
            mode_q == x25rx_pkg::MODE_AWAIT_RESET) begin
          mode_d = x25rx_pkg::MODE_AWAIT_CLEAR;
          res_d.flush_queues = 1'b1;
        end else begin
          res_d.status_code = x25rx_pkg::STAT_UNEXPECTED;
        end
      end
      x25rx_pkg::KIND_DATA_SENT: begin
        if (mode_q == x25rx_pkg::MODE_CONNECTED) begin
          vs_d = vs_q + 3'd1;
        end else begin
          res_d.status_code = x25rx_pkg::STAT_UNEXPECTED;
        end
      end
      default: begin
        // Packets from the peer, handled per circuit state
        unique case (mode_q)
          x25rx_pkg::MODE_AWAIT_ACCEPT: begin
            if (head_i.kind == x25rx_pkg::KIND_CALL_ACCEPTED) begin
              vs_d = '0; va_d = '0; vr_d = '0; vl_d = '0;
              peer_d = 1'b0; own_d = 1'b0; ackp_d = 1'b0;
              mode_d = x25rx_pkg::MODE_CONNECTED;
              res_d.timer_write = 1'b1;
            end else if (head_i.kind == x25rx_pkg::KIND_CLEAR_REQ) begin
              res_d.flush_queues = 1'b1;
              mode_d = x25rx_pkg::MODE_IDLE;
              res_d.status_code = x25rx_pkg::STAT_REFUSED;
            end else begin
              res_d.status_code = x25rx_pkg::STAT_UNEXPECTED;
            end
          end
          x25rx_pkg::MODE_AWAIT_CLEAR: begin
            if (head_i.kind == x25rx_pkg::KIND_CLEAR_REQ ||
                head_i.kind == x25rx_pkg::KIND_CLEAR_CONF) begin
              mode_d = x25rx_pkg::MODE_IDLE;
            end else begin
              res_d.status_code = x25rx_pkg::STAT_UNEXPECTED;
            end
          end
          x25rx_pkg::MODE_CONNECTED: begin
            if (head_i.kind == x25rx_pkg::KIND_RESET_REQ) begin
              res_d.flush_queues = 1'b1;
              res_d.send_packet  = x25rx_pkg::SEND_RESET_CONF;
              vs_d = '0; va_d = '0; vr_d = '0; vl_d = '0;
              peer_d = 1'b0; own_d = 1'b0; ackp_d = 1'b0;
              res_d.timer_write = 1'b1;
            end else if (head_i.kind == x25rx_pkg::KIND_CLEAR_REQ) begin
              res_d.flush_queues = 1'b1;
              res_d.send_packet  = x25rx_pkg::SEND_CLEAR_CONF;
              mode_d = x25rx_pkg::MODE_IDLE;
            end else if (head_i.kind == x25rx_pkg::KIND_RR ||
                         head_i.kind == x25rx_pkg::KIND_RNR ||
                         head_i.kind == x25rx_pkg::KIND_DATA) begin
              peer_d = (head_i.kind == x25rx_pkg::KIND_RNR);
              if (!nr_ok) begin
                // Bad N(R): request a reset
                res_d.flush_queues = 1'b1;
                res_d.send_packet  = x25rx_pkg::SEND_RESET_REQ;
                vs_d = '0; va_d = '0; vr_d = '0; vl_d = '0;
                peer_d = 1'b0; own_d = 1'b0; ackp_d = 1'b0;
                mode_d = x25rx_pkg::MODE_AWAIT_RESET;
                res_d.timer_write = 1'b1;
                res_d.timer_value = cfg_i.reset_timer_ticks;
              end else begin
                res_d.ack_update = (va_q != head_i.ack_seq);
                va_d = head_i.ack_seq;
                if (head_i.kind == x25rx_pkg::KIND_DATA && !own_q) begin
                  if (head_i.rx_seq == vr_q) begin
                    if (head_i.rx_space_ok) begin
                      vr_d = vr_q + 3'd1;
                      res_d.deliver      = 1'b1;
                      res_d.more_follows = head_i.more_bit;
                    end else begin
                      own_d = 1'b1;
                    end
                  end
                  // Force an acknowledgement once the window fills
                  ack_mark = vl_q + cfg_i.window_size;
                  res_d.timer_write = 1'b1;
                  if (ack_mark == vr_d) begin
                    ackp_d = 1'b0;
                    res_d.send_packet = own_d ? x25rx_pkg::SEND_RNR : x25rx_pkg::SEND_RR;
                    vl_d = vr_d;
                  end else begin
                    ackp_d = 1'b1;
                    res_d.timer_value = cfg_i.holdback_ticks;
                  end
                end
              end
            end else begin
              res_d.status_code = x25rx_pkg::STAT_UNEXPECTED;
            end
          end
          x25rx_pkg::MODE_AWAIT_RESET: begin
            if (head_i.kind == x25rx_pkg::KIND_RESET_REQ ||
                head_i.kind == x25rx_pkg::KIND_RESET_CONF) begin
              vs_d = '0; va_d = '0; vr_d = '0; vl_d = '0;
              peer_d = 1'b0; own_d = 1'b0; ackp_d = 1'b0;
              mode_d = x25rx_pkg::MODE_CONNECTED;
              res_d.timer_write = 1'b1;
            end else if (head_i.kind == x25rx_pkg::KIND_CLEAR_REQ) begin
              res_d.flush_queues = 1'b1;
              res_d.send_packet  = x25rx_pkg::SEND_CLEAR_CONF;
              res_d.timer_write  = 1'b1;
              mode_d = x25rx_pkg::MODE_IDLE;
            end else begin
              res_d.status_code = x25rx_pkg::STAT_UNEXPECTED;
            end
          end
          default: begin
            // Idle: peer packets are dropped quietly
            res_d.status_code = x25rx_pkg::STAT_OK;
          end
        endcase
      end
    endcase

    res_d.acked_upto    = va_d;
    res_d.circuit_state = mode_d;
    res_d.peer_busy     = peer_d;
    res_d.own_busy      = own_d;

    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      out_valid_d = 1'b1;
    end
  end

  // Circuit state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= x25rx_pkg::MODE_IDLE;
      vs_q        <= '0;
      va_q        <= '0;
      vr_q        <= '0;
      vl_q        <= '0;
      peer_q      <= 1'b0;
      own_q       <= 1'b0;
      ackp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        mode_q <= mode_d;
        vs_q   <= vs_d;
        va_q   <= va_d;
        vr_q   <= vr_d;
        vl_q   <= vl_d;
        peer_q <= peer_d;
        own_q  <= own_d;
        ackp_q <= ackp_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule
